[sv/sws_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the stack with search block.
// No dependencies; imported by sws_mem and stack_with_search.
package sws_pkg;

  // Number of stack entries
  localparam int unsigned DEPTH  = 128;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NOP    = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // Memory access issued by the sequencer in one cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

[sv/sws_mem.sv]
`timescale 1ns / 1ps
// Stack storage: one write port, one read port with registered read data.
// Depends on sws_pkg.
module sws_mem (
  input  logic                      clk_i,
  input  sws_pkg::mem_req_t         req_i,
  output logic [sws_pkg::WORD_W-1:0] rdata_o
);
  import sws_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/stack_with_search.sv]
`timescale 1ns / 1ps
// LIFO stack of 32-bit words with a bottom-up linear search.
// Path from accept to output register: push, full, empty and no-op go through S_WAIT_OUT,
// pop adds S_POP_RD (one memory read), search adds S_SCAN (one entry per cycle).
// One item at a time: the input stalls until the result is registered, and
// S_WAIT_OUT holds the result back while the output stalls.
// Reset (async, active low) empties the stack; entry contents are not cleared.
module stack_with_search (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        opcode_i,
  input  logic signed [sws_pkg::WORD_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        status_o,
  output logic signed [sws_pkg::WORD_W-1:0] popped_value_o
);
  import sws_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_RD,
    S_SCAN,
    S_WAIT_OUT
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  idx_q;
  logic [WORD_W-1:0] key_q;
  status_e           res_status_q;
  logic [WORD_W-1:0] res_pop_q;
  logic              out_valid_q;
  status_e           out_status_q;
  logic [WORD_W-1:0] out_pop_q;

  mem_req_t          mem_req;
  logic [WORD_W-1:0] rdata;
  logic              in_acc;
  logic              out_free;
  logic              is_full;
  logic              is_empty;
  logic [CNT_W-1:0]  top_idx;
  opcode_e           op;

  assign op       = opcode_e'(opcode_i);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign is_empty = (count_q == '0);
  assign top_idx  = count_q - CNT_W'(1);

  // Memory request: push writes on accept, pop/search read addresses
  always_comb begin
    mem_req       = '0;
    mem_req.waddr = count_q[ADDR_W-1:0];
    mem_req.wdata = value_i;
    mem_req.raddr = idx_q[ADDR_W-1:0];
    if (state_q == S_IDLE) begin
      mem_req.we    = in_acc && (op == OP_PUSH) && !is_full;
      mem_req.raddr = (op == OP_POP) ? top_idx[ADDR_W-1:0] : '0;
    end
  end

  sws_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // Sequencer with result and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      key_q        <= '0;
      res_status_q <= ST_DONE;
      res_pop_q    <= '0;
      out_status_q <= ST_DONE;
      out_pop_q    <= '0;
    end else begin
      // S_WAIT_OUT reloads the output register itself
      if (out_valid_q && !out_stall_i && (state_q != S_WAIT_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            res_status_q <= ST_DONE;
            res_pop_q    <= '0;
            key_q        <= value_i;
            state_q      <= S_WAIT_OUT;
            case (op)
              OP_PUSH: begin
                if (is_full) begin
                  res_status_q <= ST_FULL;
                end else begin
                  count_q <= count_q + CNT_W'(1);
                end
              end
              OP_POP: begin
                if (is_empty) begin
                  res_status_q <= ST_EMPTY;
                end else begin
                  count_q <= top_idx;
                  state_q <= S_POP_RD;
                end
              end
              OP_SEARCH: begin
                if (is_empty) begin
                  res_status_q <= ST_EMPTY;
                end else begin
                  idx_q   <= CNT_W'(1);
                  state_q <= S_SCAN;
                end
              end
              default: begin
                res_status_q <= ST_DONE;
              end
            endcase
          end
        end
        S_POP_RD: begin
          res_pop_q <= rdata;
          state_q   <= S_WAIT_OUT;
        end
        S_SCAN: begin
          // rdata holds entry idx_q - 1
          if (rdata == key_q) begin
            res_status_q <= ST_FOUND;
            state_q      <= S_WAIT_OUT;
          end else if (idx_q == count_q) begin
            res_status_q <= ST_NOT_FOUND;
            state_q      <= S_WAIT_OUT;
          end else begin
            idx_q <= idx_q + CNT_W'(1);
          end
        end
        S_WAIT_OUT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_pop_q    <= res_pop_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign popped_value_o = out_pop_q;

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op == OP_PUSH && !is_full) |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("push did not grow the stack");

  a_scan_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (idx_q != '0 && idx_q <= count_q))
    else $error("scan index out of range");

  a_pop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != ST_DONE) |-> out_pop_q == '0)
    else $error("popped value nonzero on a failed or non-pop item");

endmodule
